// File: hdl/fafr_pkg.sv
// shared types and codes for the frame allocator with fifo replacement
package fafr_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic OUT_OK  = 1'b0;
    localparam logic OUT_OOM = 1'b1;

    localparam int GRANT_W     = 10;
    localparam int OWNER_OUT_W = 6;

    typedef struct packed {
        logic next_we;
        logic prev_we;
    } link_we_t;

    typedef struct packed {
        logic [GRANT_W-1:0]     granted_frame;
        logic                   outcome;
        logic                   evicted;
        logic [OWNER_OUT_W-1:0] evicted_owner;
    } result_t;

endpackage

// File: hdl/fafr_link_ram.sv
// link store: next and prev links of every frame, one read port, masked writes
module fafr_link_ram #(
    parameter int FRAME_COUNT = 1024,
    parameter int IDX_W       = 10
) (
    input  logic                 clk,
    input  fafr_pkg::link_we_t   we,
    input  logic [IDX_W-1:0]     next_waddr,
    input  logic [IDX_W-1:0]     next_wdata,
    input  logic [IDX_W-1:0]     prev_waddr,
    input  logic [IDX_W-1:0]     prev_wdata,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [IDX_W-1:0]     rd_next,
    output logic [IDX_W-1:0]     rd_prev
);
    import fafr_pkg::*;

    logic [IDX_W-1:0] next_mem [FRAME_COUNT];
    logic [IDX_W-1:0] prev_mem [FRAME_COUNT];

    always_ff @(posedge clk)
    begin
        if (we.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (we.prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        rd_next <= next_mem[rd_addr];
        rd_prev <= prev_mem[rd_addr];
    end

endmodule

// File: hdl/fafr_info_ram.sv
// frame info store: mapped flag and owner of every frame
module fafr_info_ram #(
    parameter int FRAME_COUNT = 1024,
    parameter int IDX_W       = 10,
    parameter int OWNER_BITS  = 6
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [IDX_W-1:0]      waddr,
    input  logic                  wmapped,
    input  logic [OWNER_BITS-1:0] wowner,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic                  rd_mapped,
    output logic [OWNER_BITS-1:0] rd_owner
);
    import fafr_pkg::*;

    logic [OWNER_BITS:0] info_mem [FRAME_COUNT];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            info_mem[waddr] <= {wmapped, wowner};
        end
        {rd_mapped, rd_owner} <= info_mem[rd_addr];
    end

endmodule

// File: hdl/fafr_ctrl.sv
// command sequencer: list heads, tails and counts, read-modify-write of the stores
module fafr_ctrl #(
    parameter int FRAME_COUNT = 1024,
    parameter int OWNER_BITS  = 6,
    parameter int IDX_W       = 10,
    parameter int CNT_W       = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [9:0]            frame_index,
    input  logic [5:0]            owner,
    output logic                  res_valid,
    input  logic                  res_ready,
    output fafr_pkg::result_t     res,
    output fafr_pkg::link_we_t    link_we,
    output logic [IDX_W-1:0]      next_waddr,
    output logic [IDX_W-1:0]      next_wdata,
    output logic [IDX_W-1:0]      prev_waddr,
    output logic [IDX_W-1:0]      prev_wdata,
    output logic [IDX_W-1:0]      rd_addr,
    input  logic [IDX_W-1:0]      rd_next,
    input  logic [IDX_W-1:0]      rd_prev,
    output logic                  info_we,
    output logic [IDX_W-1:0]      info_waddr,
    output logic                  info_wmapped,
    output logic [OWNER_BITS-1:0] info_wowner,
    input  logic                  rd_mapped,
    input  logic [OWNER_BITS-1:0] rd_owner
);
    import fafr_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAME_COUNT - 1);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_ALLOC  = 6'b000100,
        S_UNLINK = 6'b001000,
        S_APPEND = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        init_reg, init_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    idx_ok_reg, idx_ok_next;
    logic [OWNER_BITS-1:0]   owner_reg, owner_next;
    logic [IDX_W-1:0]        node_reg, node_next;
    logic                    evict_reg, evict_next;
    logic [IDX_W-1:0]        free_head_reg, free_head_next;
    logic [IDX_W-1:0]        free_tail_reg, free_tail_next;
    logic [IDX_W-1:0]        fifo_head_reg, fifo_head_next;
    logic [IDX_W-1:0]        fifo_tail_reg, fifo_tail_next;
    logic [CNT_W-1:0]        free_count_reg, free_count_next;
    logic [CNT_W-1:0]        fifo_count_reg, fifo_count_next;
    result_t                 res_reg, res_next;
    logic [CNT_W-1:0]        fifo_left;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // fifo length once the evicted head is gone
    assign fifo_left = evict_reg ? fifo_count_reg - CNT_W'(1) : fifo_count_reg;

    assign rd_addr = (cmd == CMD_FREE) ? IDX_W'(frame_index)
                   : ((free_count_reg != '0) ? free_head_reg : fifo_head_reg);

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        idx_next        = idx_reg;
        idx_ok_next     = idx_ok_reg;
        owner_next      = owner_reg;
        node_next       = node_reg;
        evict_next      = evict_reg;
        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        fifo_head_next  = fifo_head_reg;
        fifo_tail_next  = fifo_tail_reg;
        free_count_next = free_count_reg;
        fifo_count_next = fifo_count_reg;
        res_next        = res_reg;
        link_we         = '0;
        next_waddr      = idx_reg;
        next_wdata      = idx_reg;
        prev_waddr      = idx_reg;
        prev_wdata      = idx_reg;
        info_we         = 1'b0;
        info_waddr      = idx_reg;
        info_wmapped    = 1'b0;
        info_wowner     = owner_reg;

        unique case (state_reg)
            S_INIT:
            begin
                // clearing pass: links in order, nothing mapped
                link_we.next_we = 1'b1;
                link_we.prev_we = 1'b1;
                next_waddr      = init_reg;
                next_wdata      = (init_reg == LAST) ? '0 : init_reg + IDX_W'(1);
                prev_waddr      = init_reg;
                prev_wdata      = (init_reg == '0) ? LAST : init_reg - IDX_W'(1);
                info_we         = 1'b1;
                info_waddr      = init_reg;
                info_wmapped    = 1'b0;
                info_wowner     = '0;
                if (init_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_next = init_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next    = IDX_W'(frame_index);
                    idx_ok_next = (32'(frame_index) < 32'(FRAME_COUNT));
                    owner_next  = OWNER_BITS'(owner);
                    evict_next  = 1'b0;
                    res_next    = '{granted_frame: '0, outcome: OUT_OK,
                                    evicted: 1'b0, evicted_owner: '0};
                    if (cmd == CMD_FREE)
                    begin
                        state_next = S_UNLINK;
                    end
                    else if (free_count_reg != '0)
                    begin
                        node_next  = free_head_reg;
                        state_next = S_ALLOC;
                    end
                    else if (fifo_count_reg != '0)
                    begin
                        node_next  = fifo_head_reg;
                        evict_next = 1'b1;
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        res_next.outcome = OUT_OOM;
                        state_next       = S_DONE;
                    end
                end
            end
            S_ALLOC:
            begin
                if (evict_reg)
                begin
                    fifo_head_next = rd_next;
                end
                else
                begin
                    free_head_next  = rd_next;
                    free_count_next = free_count_reg - CNT_W'(1);
                end
                if (fifo_left == '0)
                begin
                    fifo_head_next = node_reg;
                end
                else
                begin
                    link_we.next_we = 1'b1;
                    link_we.prev_we = 1'b1;
                    next_waddr      = fifo_tail_reg;
                    next_wdata      = node_reg;
                    prev_waddr      = node_reg;
                    prev_wdata      = fifo_tail_reg;
                end
                fifo_tail_next  = node_reg;
                fifo_count_next = fifo_left + CNT_W'(1);
                info_we         = 1'b1;
                info_waddr      = node_reg;
                info_wmapped    = 1'b1;
                info_wowner     = owner_reg;
                res_next.granted_frame = GRANT_W'(node_reg);
                res_next.evicted       = evict_reg;
                res_next.evicted_owner = evict_reg ? OWNER_OUT_W'(rd_owner) : '0;
                state_next = S_DONE;
            end
            S_UNLINK:
            begin
                if (idx_ok_reg && rd_mapped)
                begin
                    if (idx_reg == fifo_head_reg)
                    begin
                        fifo_head_next = rd_next;
                    end
                    else
                    begin
                        link_we.next_we = 1'b1;
                        next_waddr      = rd_prev;
                        next_wdata      = rd_next;
                    end
                    if (idx_reg == fifo_tail_reg)
                    begin
                        fifo_tail_next = rd_prev;
                    end
                    else
                    begin
                        link_we.prev_we = 1'b1;
                        prev_waddr      = rd_next;
                        prev_wdata      = rd_prev;
                    end
                    fifo_count_next = fifo_count_reg - CNT_W'(1);
                    info_we         = 1'b1;
                    info_waddr      = idx_reg;
                    info_wmapped    = 1'b0;
                    info_wowner     = rd_owner;
                    state_next      = S_APPEND;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_APPEND:
            begin
                if (free_count_reg == '0)
                begin
                    free_head_next = idx_reg;
                end
                else
                begin
                    link_we.next_we = 1'b1;
                    link_we.prev_we = 1'b1;
                    next_waddr      = free_tail_reg;
                    next_wdata      = idx_reg;
                    prev_waddr      = idx_reg;
                    prev_wdata      = free_tail_reg;
                end
                free_tail_next  = idx_reg;
                free_count_next = free_count_reg + CNT_W'(1);
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_reg       <= '0;
            free_head_reg  <= '0;
            free_tail_reg  <= LAST;
            fifo_head_reg  <= '0;
            fifo_tail_reg  <= '0;
            free_count_reg <= CNT_W'(FRAME_COUNT);
            fifo_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            fifo_head_reg  <= fifo_head_next;
            fifo_tail_reg  <= fifo_tail_next;
            free_count_reg <= free_count_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        idx_ok_reg <= idx_ok_next;
        owner_reg  <= owner_next;
        node_reg   <= node_next;
        evict_reg  <= evict_next;
        res_reg    <= res_next;
    end

    // every frame sits on exactly one list between commands
    a_frames_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
        (32'(free_count_reg) + 32'(fifo_count_reg) == 32'(FRAME_COUNT)))
        else $error("frame counts do not add up to the pool size");

    a_oom_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_reg.outcome == OUT_OOM) |->
        (free_count_reg == '0 && fifo_count_reg == '0))
        else $error("out of memory reported with frames left");

    a_evict_only_when_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC && evict_reg) |-> (free_count_reg == '0))
        else $error("eviction while the free list holds frames");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |->
        (!link_we.next_we && !link_we.prev_we && !info_we))
        else $error("store written outside a command step");

endmodule

// File: hdl/frame_allocator_fifo_replace.sv
// top level of the frame allocator with fifo replacement and its output register
//
// Input channel in_valid/in_ready carries one item: cmd (allocate or free),
// frame_index (frame to free) and owner (id recorded on allocate). Output
// channel out_valid/out_ready returns one result item per input item, in
// order: granted_frame, outcome, evicted and evicted_owner.
// Each item is a read of the link and info stores followed by at most two
// write steps, so the block works on one item at a time. After acceptance an
// allocate passes S_ALLOC, a free of a mapped frame S_UNLINK and S_APPEND, a
// free of an unmapped frame S_UNLINK, out-of-memory none; each ends in S_DONE,
// which hands the result to the output register. The next item is taken once
// the sequencer is back in S_IDLE. After reset a clearing pass writes the
// initial links and clears the info store; in_ready stays low during it.
// A result waits in the output register while out_ready is low, and the next
// item is accepted and worked on meanwhile; that item's result then holds in
// the sequencer until the output register is free.
module frame_allocator_fifo_replace #(
    parameter int FRAME_COUNT = 1024,
    parameter int OWNER_BITS  = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [9:0] frame_index,
    input  logic [5:0] owner,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [9:0] granted_frame,
    output logic       outcome,
    output logic       evicted,
    output logic [5:0] evicted_owner
);
    import fafr_pkg::*;

    localparam int IDX_W = $clog2(FRAME_COUNT);
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);

    link_we_t              link_we;
    logic [IDX_W-1:0]      next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic [IDX_W-1:0]      rd_addr, rd_next, rd_prev;
    logic                  info_we, info_wmapped, rd_mapped;
    logic [IDX_W-1:0]      info_waddr;
    logic [OWNER_BITS-1:0] info_wowner, rd_owner;
    logic                  res_valid, res_ready;
    result_t               res;

    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    fafr_ctrl #(
        .FRAME_COUNT (FRAME_COUNT),
        .OWNER_BITS  (OWNER_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .frame_index  (frame_index),
        .owner        (owner),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .link_we      (link_we),
        .next_waddr   (next_waddr),
        .next_wdata   (next_wdata),
        .prev_waddr   (prev_waddr),
        .prev_wdata   (prev_wdata),
        .rd_addr      (rd_addr),
        .rd_next      (rd_next),
        .rd_prev      (rd_prev),
        .info_we      (info_we),
        .info_waddr   (info_waddr),
        .info_wmapped (info_wmapped),
        .info_wowner  (info_wowner),
        .rd_mapped    (rd_mapped),
        .rd_owner     (rd_owner)
    );

    fafr_link_ram #(
        .FRAME_COUNT (FRAME_COUNT),
        .IDX_W       (IDX_W)
    ) u_link_ram (
        .clk        (clk),
        .we         (link_we),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .rd_addr    (rd_addr),
        .rd_next    (rd_next),
        .rd_prev    (rd_prev)
    );

    fafr_info_ram #(
        .FRAME_COUNT (FRAME_COUNT),
        .IDX_W       (IDX_W),
        .OWNER_BITS  (OWNER_BITS)
    ) u_info_ram (
        .clk       (clk),
        .we        (info_we),
        .waddr     (info_waddr),
        .wmapped   (info_wmapped),
        .wowner    (info_wowner),
        .rd_addr   (rd_addr),
        .rd_mapped (rd_mapped),
        .rd_owner  (rd_owner)
    );

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign granted_frame = out_reg.granted_frame;
    assign outcome       = out_reg.outcome;
    assign evicted       = out_reg.evicted;
    assign evicted_owner = out_reg.evicted_owner;

endmodule
